### rtl/core/twil_pkg.sv
// Shared constants, types and request structures of the trie word engine.
package twil_pkg;

   localparam int NODES    = 4096;
   localparam int ALPHABET = 26;
   localparam int LETTER_W = 5;
   localparam int NODE_W   = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int FREE_W   = $clog2(NODES + 1);
   localparam int SLOT_W   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int ROW_W    = ALPHABET * NODE_W;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_SEARCH = 1'b1;

   // One memory row holds every child link of one node.
   typedef logic [ALPHABET-1:0][NODE_W-1:0] row_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_END,
      ST_PROBE
   } state_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [NODE_W-1:0] addr;
      row_type           wr_data;
   } child_req_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [NODE_W-1:0] addr;
      logic              wr_data;
   } mark_req_type;

   typedef struct packed {
      logic valid;
      logic found;
      logic overflow;
   } result_type;

endpackage

### rtl/core/trie_word_insert_lookup.sv
// Top level of the trie word engine: link and mark memories, walk sequencer, result register.
//
// Words arrive one letter per transaction, the final letter flagged by tlast and the kind of
// walk (insert or search) carried on tuser. Every node of the trie owns one row of the link
// memory holding a child link for each letter, so a letter costs one read of the current
// node's row and, in the cycle after, the choice of the child and, when an insert allocates
// a new node, the write-back of the updated row; the next letter is not taken until that
// read-modify-write on the single port of the link memory is done. The final letter of a
// word then passes an end state that sets or tests the word-end mark, and a search also a
// probe state, as the mark memory has a registered read. Exactly one response transaction
// follows each final letter: found for a search, overflow for an insert whose word could
// not be stored (node pool exhausted, or a letter outside the alphabet). The response sits
// in an output register, so the next word's letters are taken while it waits; only a
// further final letter stalls until that register is free. After reset the block clears
// both memories, one node per cycle, and holds req_tready low until then.
module trie_word_insert_lookup (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [4:0] letter, [7:5] zero
   input  logic       req_tuser,   // [0] action: 0 insert, 1 search
   input  logic       req_tlast,   // final letter of the word
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] found, [1] overflow, [7:2] zero
);

   twil_pkg::child_req_type child_req;
   twil_pkg::mark_req_type  mark_req;
   twil_pkg::result_type    result;
   logic [twil_pkg::ROW_W-1:0] child_rd_raw;
   logic                    mark_rd_data;
   logic                    result_ready;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff, rsp_found_in;
   logic rsp_overflow_ff, rsp_overflow_in;

   twil_ram #(
      .WIDTH (twil_pkg::ROW_W),
      .DEPTH (twil_pkg::NODES)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (child_req.wr_en),
      .rd_en   (child_req.rd_en),
      .addr    (child_req.addr),
      .wr_data (child_req.wr_data),
      .rd_data (child_rd_raw)
   );

   twil_ram #(
      .WIDTH (1),
      .DEPTH (twil_pkg::NODES)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_req.wr_en),
      .rd_en   (mark_req.rd_en),
      .addr    (mark_req.addr),
      .wr_data (mark_req.wr_data),
      .rd_data (mark_rd_data)
   );

   twil_walk u_walk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_action    (req_tuser),
      .req_letter    (req_tdata[twil_pkg::LETTER_W-1:0]),
      .req_last      (req_tlast),
      .req_ready     (req_tready),
      .child_req     (child_req),
      .child_rd_data (twil_pkg::row_type'(child_rd_raw)),
      .mark_req      (mark_req),
      .mark_rd_data  (mark_rd_data),
      .result        (result),
      .result_ready  (result_ready)
   );

   // The response register may take a new result when empty or when it drains this cycle.
   assign result_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_found_in    = rsp_found_ff;
      rsp_overflow_in = rsp_overflow_ff;
      if (result.valid) begin
         rsp_valid_in    = 1'b1;
         rsp_found_in    = result.found;
         rsp_overflow_in = result.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff    <= rsp_found_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_overflow_ff, rsp_found_ff};

endmodule

### rtl/core/twil_ram.sv
// Generic single-port synchronous RAM with a registered read.
module twil_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/twil_walk.sv
// Trie walk sequencer: clears the store, follows and allocates links, marks word ends.
module twil_walk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_action,
   input  logic [twil_pkg::LETTER_W-1:0] req_letter,
   input  logic                          req_last,
   output logic                          req_ready,
   output twil_pkg::child_req_type       child_req,
   input  twil_pkg::row_type             child_rd_data,
   output twil_pkg::mark_req_type        mark_req,
   input  logic                          mark_rd_data,
   output twil_pkg::result_type          result,
   input  logic                          result_ready
);

   twil_pkg::state_type               state_ff, state_in;
   logic [twil_pkg::NODE_W-1:0]       clr_ff, clr_in;
   logic [twil_pkg::NODE_W-1:0]       cursor_ff, cursor_in;
   logic [twil_pkg::FREE_W-1:0]       next_free_ff, next_free_in;
   logic                              broken_ff, broken_in;
   logic                              action_ff, action_in;
   logic [twil_pkg::LETTER_W-1:0]     letter_ff, letter_in;
   logic                              last_ff, last_in;

   logic                              letter_bad;
   logic                              pool_empty;
   logic [twil_pkg::SLOT_W-1:0]       slot;
   logic [twil_pkg::NODE_W-1:0]       child;
   twil_pkg::row_type                 row_wr;

   assign letter_bad = 32'(letter_ff) >= 32'(twil_pkg::ALPHABET);
   assign pool_empty = next_free_ff >= twil_pkg::FREE_W'(twil_pkg::NODES);
   assign slot       = twil_pkg::SLOT_W'(letter_ff);
   assign child      = child_rd_data[slot];

   always_comb begin
      row_wr       = child_rd_data;
      row_wr[slot] = next_free_ff[twil_pkg::NODE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= twil_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         next_free_ff <= twil_pkg::FREE_W'(1);
         broken_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         next_free_ff <= next_free_in;
         broken_ff    <= broken_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      letter_ff <= letter_in;
      last_ff   <= last_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         twil_pkg::ST_CLEAR: begin
            if (clr_ff == twil_pkg::NODE_W'(twil_pkg::NODES - 1)) begin
               state_in = twil_pkg::ST_IDLE;
            end
         end
         twil_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = twil_pkg::ST_STEP;
            end
         end
         twil_pkg::ST_STEP: begin
            state_in = last_ff ? twil_pkg::ST_END : twil_pkg::ST_IDLE;
         end
         twil_pkg::ST_END: begin
            if (!broken_ff && action_ff == twil_pkg::ACT_SEARCH) begin
               state_in = twil_pkg::ST_PROBE;
            end else if (result_ready) begin
               state_in = twil_pkg::ST_IDLE;
            end
         end
         twil_pkg::ST_PROBE: begin
            if (result_ready) begin
               state_in = twil_pkg::ST_IDLE;
            end
         end
         default: state_in = twil_pkg::ST_CLEAR;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      clr_in            = clr_ff;
      cursor_in         = cursor_ff;
      next_free_in      = next_free_ff;
      broken_in         = broken_ff;
      action_in         = action_ff;
      letter_in         = letter_ff;
      last_in           = last_ff;
      req_ready         = 1'b0;
      child_req.rd_en   = 1'b0;
      child_req.wr_en   = 1'b0;
      child_req.addr    = cursor_ff;
      child_req.wr_data = row_wr;
      mark_req.rd_en    = 1'b0;
      mark_req.wr_en    = 1'b0;
      mark_req.addr     = cursor_ff;
      mark_req.wr_data  = 1'b1;
      result            = '0;
      case (state_ff)
         twil_pkg::ST_CLEAR: begin
            child_req.wr_en   = 1'b1;
            child_req.addr    = clr_ff;
            child_req.wr_data = '0;
            mark_req.wr_en    = 1'b1;
            mark_req.addr     = clr_ff;
            mark_req.wr_data  = 1'b0;
            clr_in            = clr_ff + twil_pkg::NODE_W'(1);
         end
         twil_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               child_req.rd_en = 1'b1;
               action_in       = req_action;
               letter_in       = req_letter;
               last_in         = req_last;
            end
         end
         twil_pkg::ST_STEP: begin
            if (!broken_ff) begin
               if (letter_bad) begin
                  broken_in = 1'b1;
               end else if (child != '0) begin
                  cursor_in = child;
               end else if (action_ff == twil_pkg::ACT_SEARCH || pool_empty) begin
                  broken_in = 1'b1;
               end else begin
                  child_req.wr_en = 1'b1;
                  cursor_in       = next_free_ff[twil_pkg::NODE_W-1:0];
                  next_free_in    = next_free_ff + twil_pkg::FREE_W'(1);
               end
            end
         end
         twil_pkg::ST_END: begin
            if (!broken_ff && action_ff == twil_pkg::ACT_SEARCH) begin
               mark_req.rd_en = 1'b1;
            end else if (result_ready) begin
               // A search that lost its path simply reports not found.
               result.valid    = 1'b1;
               result.overflow = broken_ff && (action_ff == twil_pkg::ACT_INSERT);
               mark_req.wr_en  = !broken_ff;
               cursor_in       = '0;
               broken_in       = 1'b0;
            end
         end
         twil_pkg::ST_PROBE: begin
            if (result_ready) begin
               result.valid = 1'b1;
               result.found = mark_rd_data;
               cursor_in    = '0;
               broken_in    = 1'b0;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule
